// ----- rtl/upds_pkg.sv -----
// Shared types and constants for the USB printer descriptor scanner.
// Holds the input and result word layouts, register indexes and record codes.
// No dependencies.
package upds_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic        printer_found;
    logic        endpoint_ready;
    logic [7:0]  interface_number;
    logic [7:0]  alt_setting;
    logic [7:0]  endpoint_address;
    logic [15:0] max_packet_size;
    logic [21:0] buffer_bytes;
    logic        scan_done;
    logic        truncated;
  } out_word_t;

  // Findings and scan status after the latest word, as seen by the output stage.
  typedef struct packed {
    logic        printer_found;
    logic        endpoint_ready;
    logic [15:0] found_interface;
    logic [23:0] found_endpoint;
    logic        scan_done;
    logic        truncated;
  } scan_view_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRINTER_CLASS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINTER_SUBCLASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKETS_PER_XFER = 2'd2;

  localparam logic [7:0] RESET_PRINTER_CLASS    = 8'h07;
  localparam logic [7:0] RESET_PRINTER_SUBCLASS = 8'h01;
  localparam logic [6:0] RESET_PACKETS_PER_XFER = 7'd8;
  localparam logic [6:0] PACKETS_MAX            = 7'd64;

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_DETACH = 1'b1;

  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
  localparam logic [7:0] PROTO_UNIDIR   = 8'h01;
  localparam logic [7:0] PROTO_BIDIR    = 8'h02;
  localparam logic [1:0] XFER_BULK      = 2'b10;

endpackage

// ----- rtl/upds_parser.sv -----
// Record walker of the descriptor scanner: holds the scan state and findings.
// Takes one word per accepted cycle and updates its state in that cycle.
// Depends on upds_pkg.
module upds_parser import upds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_word_t   word,
  input  logic [7:0] printer_class,
  input  logic [7:0] printer_subclass,
  output scan_view_t view
);

  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  rec_offset_r, rec_offset_nxt;
  logic [7:0]  rec_length_r, rec_length_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [7:0]  rec_bytes_r [6];
  logic [7:0]  rec_bytes_nxt [6];
  logic        in_printer_r, in_printer_nxt;
  logic        found_r, found_nxt;
  logic        endpoint_r, endpoint_nxt;
  logic [15:0] found_if_r, found_if_nxt;
  logic [23:0] found_ep_r, found_ep_nxt;
  logic        stopped_r, stopped_nxt;
  logic        trunc_r, trunc_nxt;

  always_comb begin
    logic [15:0] pos;
    logic [7:0]  off;
    logic [7:0]  b;
    logic        halt;
    logic        match;
    byte_index_nxt   = byte_index_r;
    total_length_nxt = total_length_r;
    rec_offset_nxt   = rec_offset_r;
    rec_length_nxt   = rec_length_r;
    rec_type_nxt     = rec_type_r;
    rec_bytes_nxt    = rec_bytes_r;
    in_printer_nxt   = in_printer_r;
    found_nxt        = found_r;
    endpoint_nxt     = endpoint_r;
    found_if_nxt     = found_if_r;
    found_ep_nxt     = found_ep_r;
    stopped_nxt      = stopped_r;
    trunc_nxt        = trunc_r;
    pos   = 16'd0;
    off   = 8'd0;
    b     = word.data_byte;
    halt  = 1'b0;
    match = 1'b0;
    if (take) begin
      if (word.req_type == REQ_DETACH) begin
        found_nxt      = 1'b0;
        endpoint_nxt   = 1'b0;
        found_if_nxt   = 16'd0;
        found_ep_nxt   = 24'd0;
        in_printer_nxt = 1'b0;
        stopped_nxt    = 1'b1;
        trunc_nxt      = 1'b0;
      end else begin
        if (word.first_byte) begin
          byte_index_nxt   = 16'd0;
          total_length_nxt = 16'd0;
          rec_offset_nxt   = 8'd0;
          rec_length_nxt   = 8'd0;
          rec_type_nxt     = 8'd0;
          in_printer_nxt   = 1'b0;
          stopped_nxt      = 1'b0;
          trunc_nxt        = 1'b0;
        end
        if (!stopped_nxt) begin
          pos = byte_index_nxt;
          off = rec_offset_nxt;
          if (pos == 16'd2) begin
            total_length_nxt[7:0] = b;
          end else if (pos == 16'd3) begin
            total_length_nxt[15:8] = b;
          end
          if (off == 8'd0) begin
            rec_length_nxt = b;
            rec_type_nxt   = 8'd0;
            for (int i = 0; i < 6; i++) begin
              rec_bytes_nxt[i] = 8'd0;
            end
            if (b == 8'd0) begin
              stopped_nxt = 1'b1;
              trunc_nxt   = 1'b1;
              halt        = 1'b1;
            end else if (pos >= 16'd4 &&
                         ({1'b0, pos} + {9'd0, b}) > {1'b0, total_length_nxt}) begin
              stopped_nxt = 1'b1;
              trunc_nxt   = 1'b1;
              halt        = 1'b1;
            end
          end else if (off == 8'd1) begin
            rec_type_nxt = b;
          end else if (off < 8'd8) begin
            rec_bytes_nxt[off[2:0] - 3'd2] = b;
          end
          if (!halt && pos == 16'd3) begin
            if (total_length_nxt < 16'd4) begin
              stopped_nxt = 1'b1;
              trunc_nxt   = (total_length_nxt != 16'd0);
              halt        = 1'b1;
            end else if ({7'd0, 10'd3 - {2'd0, off} + {2'd0, rec_length_nxt}} >
                         {1'b0, total_length_nxt}) begin
              stopped_nxt = 1'b1;
              trunc_nxt   = 1'b1;
              halt        = 1'b1;
            end
          end
          if (!halt) begin
            if ({1'b0, off} + 9'd1 == {1'b0, rec_length_nxt}) begin
              if (rec_type_nxt == DESC_INTERFACE) begin
                match = rec_bytes_nxt[3] == printer_class &&
                        rec_bytes_nxt[4] == printer_subclass &&
                        (rec_bytes_nxt[5] == PROTO_UNIDIR || rec_bytes_nxt[5] == PROTO_BIDIR);
                in_printer_nxt = match;
                if (match && !found_nxt) begin
                  found_nxt    = 1'b1;
                  found_if_nxt = {rec_bytes_nxt[1], rec_bytes_nxt[0]};
                end
              end else if (rec_type_nxt == DESC_ENDPOINT && in_printer_nxt && found_nxt) begin
                if (rec_bytes_nxt[1][1:0] == XFER_BULK && !rec_bytes_nxt[0][7] &&
                    !endpoint_nxt) begin
                  endpoint_nxt = 1'b1;
                  found_ep_nxt = {rec_bytes_nxt[3], rec_bytes_nxt[2], rec_bytes_nxt[0]};
                end
              end
              rec_offset_nxt = 8'd0;
              if (pos >= 16'd3 && ({1'b0, pos} + 17'd1) == {1'b0, total_length_nxt}) begin
                stopped_nxt = 1'b1;
                trunc_nxt   = 1'b0;
                halt        = 1'b1;
              end
            end else begin
              rec_offset_nxt = off + 8'd1;
            end
          end
          if (!halt) begin
            byte_index_nxt = pos + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= 16'd0;
      total_length_r <= 16'd0;
      rec_offset_r   <= 8'd0;
      rec_length_r   <= 8'd0;
      rec_type_r     <= 8'd0;
      in_printer_r   <= 1'b0;
      found_r        <= 1'b0;
      endpoint_r     <= 1'b0;
      found_if_r     <= 16'd0;
      found_ep_r     <= 24'd0;
      stopped_r      <= 1'b1;
      trunc_r        <= 1'b0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      total_length_r <= total_length_nxt;
      rec_offset_r   <= rec_offset_nxt;
      rec_length_r   <= rec_length_nxt;
      rec_type_r     <= rec_type_nxt;
      in_printer_r   <= in_printer_nxt;
      found_r        <= found_nxt;
      endpoint_r     <= endpoint_nxt;
      found_if_r     <= found_if_nxt;
      found_ep_r     <= found_ep_nxt;
      stopped_r      <= stopped_nxt;
      trunc_r        <= trunc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_bytes_r <= rec_bytes_nxt;
  end

  assign view.printer_found   = found_r;
  assign view.endpoint_ready  = endpoint_r;
  assign view.found_interface = found_if_r;
  assign view.found_endpoint  = found_ep_r;
  assign view.scan_done       = stopped_r;
  assign view.truncated       = trunc_r;

endmodule

// ----- rtl/usb_printer_descriptor_scanner.sv -----
// Top level of the USB printer descriptor scanner.
// Instantiates upds_parser and holds the configuration registers and result stage.
// Depends on upds_pkg and upds_parser.
//
// Usage: each word on the in_ channel is either one byte of a configuration
// descriptor (first_byte marks the start of a scan) or a detach request.
// Every accepted word yields exactly one result word on the out_ channel,
// showing the findings and scan status after that word.
// The parser state updates at the accepting edge, and the result register,
// which also forms the buffer size product, then loads from the parser state.
// One word is accepted per cycle while in_stall is low; the parser state itself
// is the first pipeline stage, so a word waits there only while the result
// register is full and stalled. in_stall rises only in that case.
// Reset leaves no scan active, no findings, and the configuration registers at
// class 7, subclass 1 and eight packets per transfer.
// Configuration writes through cfg_we take effect at the next edge; the user
// must make them only while no result is pending, which the block does not enforce.
module usb_printer_descriptor_scanner import upds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0] class_r;
  logic [7:0] subclass_r;
  logic [6:0] packets_r;
  logic       view_valid_r, view_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  scan_view_t view;
  logic       take;
  logic       advance;
  logic [6:0] packets_eff;
  logic [21:0] product;

  assign advance  = view_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = view_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  upds_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .word             (in_data),
    .printer_class    (class_r),
    .printer_subclass (subclass_r),
    .view             (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r    <= RESET_PRINTER_CLASS;
      subclass_r <= RESET_PRINTER_SUBCLASS;
      packets_r  <= RESET_PACKETS_PER_XFER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRINTER_CLASS:    class_r    <= cfg_wdata;
        CFG_PRINTER_SUBCLASS: subclass_r <= cfg_wdata;
        CFG_PACKETS_PER_XFER: packets_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (packets_r == 7'd0) begin
      packets_eff = 7'd1;
    end else if (packets_r > PACKETS_MAX) begin
      packets_eff = PACKETS_MAX;
    end else begin
      packets_eff = packets_r;
    end
  end

  always_comb begin
    out_word_nxt = out_word_r;
    product      = 22'd0;
    if (advance) begin
      out_word_nxt.printer_found    = view.printer_found;
      out_word_nxt.endpoint_ready   = view.endpoint_ready;
      out_word_nxt.interface_number = view.printer_found ? view.found_interface[7:0] : 8'd0;
      out_word_nxt.alt_setting      = view.printer_found ? view.found_interface[15:8] : 8'd0;
      out_word_nxt.endpoint_address = view.endpoint_ready ? view.found_endpoint[7:0] : 8'd0;
      out_word_nxt.max_packet_size  = view.endpoint_ready ? view.found_endpoint[23:8] : 16'd0;
      product = {6'd0, out_word_nxt.max_packet_size} * {15'd0, packets_eff};
      out_word_nxt.buffer_bytes     = product;
      out_word_nxt.scan_done        = view.scan_done;
      out_word_nxt.truncated        = view.truncated;
    end
  end

  always_comb begin
    view_valid_nxt = take || (view_valid_r && !advance);
    out_valid_nxt  = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      view_valid_r <= view_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_stall_needs_pending : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> view_valid_r && out_valid_r)
    else $error("input stalled without a pending result");

  a_detach_clears : assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.req_type == REQ_DETACH |=> !view.printer_found && view.scan_done)
    else $error("detach did not clear the findings");

  a_endpoint_after_iface : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.endpoint_ready |-> out_data.printer_found)
    else $error("endpoint reported without a printer interface");

  a_trunc_means_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |-> out_data.scan_done)
    else $error("truncated flag set while a scan is active");

endmodule
